// ----- sv/rtr_pkg.sv -----
// rtr_pkg: types and fixed constants of the reliable transfer receiver.
// No dependencies; imported by the core and by its checker.
`default_nettype none
package rtr_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned IDX_W     = 11;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] VERD_ACCEPT    = 2'd0;
    localparam logic [1:0] VERD_REACK     = 2'd1;
    localparam logic [1:0] VERD_BAD       = 2'd2;
    localparam logic [1:0] VERD_MALFORMED = 2'd3;

    localparam logic [1:0] FLD_SEQ   = 2'd0;
    localparam logic [1:0] FLD_TYPE  = 2'd1;
    localparam logic [1:0] FLD_SIZE  = 2'd2;
    localparam logic [1:0] FLD_CHECK = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  verdict;
        logic        ack_valid;
        logic [31:0] ack_seq;
        logic [31:0] ack_checksum;
        logic        last_of_run;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/reliable_transfer_receiver_core.sv -----
// reliable_transfer_receiver_core: go-back-N receiver fed one datagram byte per word.
// Depends on rtr_pkg (result type, verdict codes, header constants).
// Result words are registered in a four-entry output queue. Throughput: one byte
// per cycle while in_ready is high; a byte with the end mark inside the payload
// yields two words, which the queue drains one per cycle while out_ready is high.
// in_ready is high while the queue holds at most two words.
// Reset: asynchronous, clears the expected sequence, datagram state and queue.
`default_nettype none
module reliable_transfer_receiver_core #(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  rx_byte,
    input  wire         end_of_datagram,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  verdict,
    output logic        ack_valid,
    output logic [31:0] ack_seq,
    output logic [31:0] ack_checksum,
    output logic        last_of_run
);
    import rtr_pkg::*;

    localparam logic [IDX_W-1:0] HDR_END  = IDX_W'(HDR_BYTES);
    localparam logic [IDX_W-1:0] PAY_END  = IDX_W'(HDR_BYTES + MAX_PAYLOAD);
    localparam logic [31:0]      MAX_SIZE = 32'(MAX_PAYLOAD);

    // Receiver state: one datagram being parsed plus the expected sequence.
    logic [31:0]      exp_seq_reg, exp_seq_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      type_reg, type_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      check_reg, check_next;
    // Sum of header sequence, type and size bytes plus counted payload bytes;
    // each header byte lands at its own bit position, so adding it equals
    // adding the assembled word.
    logic [31:0]      sum_reg, sum_next;

    // Output queue of result words.
    result_t          q_mem [4];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       count_reg, count_next;

    logic             in_fire, out_fire;
    logic [31:0]      shifted;
    logic             in_hdr, in_sum_hdr, take_payload;
    logic [IDX_W-1:0] idx_inc;
    logic [31:0]      addend;
    logic             malformed, good;
    logic [31:0]      exp_plus1;
    result_t          pay_res, ver_res, first_res;
    logic [1:0]       n_push;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (count_reg <= 3'd2);

    // Parse: place header bytes, decide whether a payload byte counts.
    always_comb
    begin
        shifted      = {24'b0, rx_byte} << {idx_reg[1:0], 3'b000};
        in_hdr       = (idx_reg < HDR_END);
        in_sum_hdr   = in_hdr && (idx_reg[3:2] != FLD_CHECK);
        take_payload = !in_hdr && (idx_reg < PAY_END)
                       && ({21'b0, idx_reg - HDR_END} < size_reg);
        idx_inc      = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + 1'b1;

        seq_next   = seq_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        check_next = check_reg;
        if (in_hdr)
        begin
            unique case (idx_reg[3:2])
                FLD_SEQ:   seq_next   = seq_reg | shifted;
                FLD_TYPE:  type_next  = type_reg | shifted;
                FLD_SIZE:  size_next  = size_reg | shifted;
                FLD_CHECK: check_next = check_reg | shifted;
                default:   check_next = check_reg;
            endcase
        end

        if (in_sum_hdr)
            addend = shifted;
        else if (take_payload)
            addend = {24'b0, rx_byte};
        else
            addend = 32'b0;
        sum_next = sum_reg + addend;
    end

    // Verdict from the state as it stands after this byte.
    always_comb
    begin
        malformed = (size_next > MAX_SIZE)
                    || ({21'b0, idx_inc} < (32'(HDR_BYTES) + size_next));
        good      = (sum_next == check_next) && (type_next == 32'b0);
        exp_plus1 = exp_seq_reg + 32'd1;

        ver_res              = '0;
        ver_res.kind         = KIND_VERDICT;
        ver_res.last_of_run  = 1'b1;
        exp_seq_next         = exp_seq_reg;
        priority if (malformed)
        begin
            ver_res.verdict = VERD_MALFORMED;
        end
        else if (!good)
        begin
            ver_res.verdict = VERD_BAD;
        end
        else if (seq_next == exp_seq_reg)
        begin
            ver_res.verdict      = VERD_ACCEPT;
            ver_res.ack_valid    = 1'b1;
            ver_res.ack_seq      = exp_seq_reg;
            ver_res.ack_checksum = exp_plus1;
            exp_seq_next         = exp_plus1;
        end
        else
        begin
            // Re-ack the last accepted sequence; zero before any was accepted.
            ver_res.verdict   = VERD_REACK;
            ver_res.ack_valid = 1'b1;
            if (exp_seq_reg == 32'b0)
            begin
                ver_res.ack_seq      = 32'b0;
                ver_res.ack_checksum = 32'd1;
            end
            else
            begin
                ver_res.ack_seq      = exp_seq_reg - 32'd1;
                ver_res.ack_checksum = exp_seq_reg;
            end
        end

        pay_res              = '0;
        pay_res.kind         = KIND_PAYLOAD;
        pay_res.payload_byte = rx_byte;
        pay_res.last_of_run  = !end_of_datagram;

        first_res = take_payload ? pay_res : ver_res;
        n_push    = {1'b0, take_payload} + {1'b0, end_of_datagram};
        if (!in_fire)
            n_push = 2'd0;

        count_next = count_reg + {1'b0, n_push} - {2'b0, out_fire};
    end

    // Hold state between words; drop datagram state at each end mark.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seq_reg <= 32'b0;
            idx_reg     <= '0;
            seq_reg     <= 32'b0;
            type_reg    <= 32'b0;
            size_reg    <= 32'b0;
            check_reg   <= 32'b0;
            sum_reg     <= 32'b0;
        end
        else if (in_fire)
        begin
            if (end_of_datagram)
            begin
                exp_seq_reg <= exp_seq_next;
                idx_reg     <= '0;
                seq_reg     <= 32'b0;
                type_reg    <= 32'b0;
                size_reg    <= 32'b0;
                check_reg   <= 32'b0;
                sum_reg     <= 32'b0;
            end
            else
            begin
                idx_reg   <= idx_inc;
                seq_reg   <= seq_next;
                type_reg  <= type_next;
                size_reg  <= size_next;
                check_reg <= check_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    // Queue storage: first word at the write pointer, a following verdict after it.
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_mem[wr_ptr_reg] <= first_res;
        if (n_push == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= ver_res;
    end

    assign out_valid    = (count_reg != 3'd0);
    assign kind         = q_mem[rd_ptr_reg].kind;
    assign payload_byte = q_mem[rd_ptr_reg].payload_byte;
    assign verdict      = q_mem[rd_ptr_reg].verdict;
    assign ack_valid    = q_mem[rd_ptr_reg].ack_valid;
    assign ack_seq      = q_mem[rd_ptr_reg].ack_seq;
    assign ack_checksum = q_mem[rd_ptr_reg].ack_checksum;
    assign last_of_run  = q_mem[rd_ptr_reg].last_of_run;

endmodule
`default_nettype wire

// ----- sv/rtr_checker.sv -----
// rtr_checker: port-level assertions for reliable_transfer_receiver_core.
// Depends on rtr_pkg (kind and verdict codes); bound to the core below.
`default_nettype none
module rtr_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire        kind,
    input wire [7:0]  payload_byte,
    input wire [1:0]  verdict,
    input wire        ack_valid,
    input wire [31:0] ack_seq,
    input wire [31:0] ack_checksum,
    input wire        last_of_run
);
    import rtr_pkg::*;

    // Hold a stalled output word: kind, payload byte, verdict and ack_seq stay stable.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(payload_byte) && $stable(verdict) && $stable(ack_seq))
        else $error("output word changed while stalled");

    a_payload_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PAYLOAD |-> !ack_valid && verdict == VERD_ACCEPT)
        else $error("payload word carries verdict fields");

    a_ack_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_valid |-> ack_checksum == ack_seq + 32'd1)
        else $error("ack checksum mismatch");

    a_drop_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_VERDICT
            && (verdict == VERD_BAD || verdict == VERD_MALFORMED) |-> !ack_valid)
        else $error("dropped datagram acknowledged");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_VERDICT |-> last_of_run)
        else $error("verdict not last of run");

endmodule

bind reliable_transfer_receiver_core rtr_checker u_rtr_checker (.*);
`default_nettype wire

// ----- test/tb.sv -----
// tb: self-checking bench for reliable_transfer_receiver_core.
// Depends on rtr_pkg and the core. Builds datagrams, predicts every result word
// and checks it against the output channel under random stalls on both sides.
module tb;
    import rtr_pkg::*;

    localparam int unsigned MAX_PAYLOAD  = 1024;
    localparam int unsigned SMALL_BYTES  = 1350;   // minimum number of input words in the run
    localparam int unsigned BIG_LEN      = 1060;   // one datagram past the payload limit
    localparam int unsigned TAIL_WORDS   = 150;    // final stretch without idling
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } rx_word_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte         = '0;
    logic        end_of_datagram = 1'b0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  verdict;
    logic        ack_valid;
    logic [31:0] ack_seq;
    logic [31:0] ack_checksum;
    logic        last_of_run;

    rx_word_t    words_to_send[$];
    result_t     results_due[$];
    int unsigned words_queued  = 0;
    int unsigned words_taken   = 0;
    int unsigned err_count     = 0;
    int unsigned stall_cycles  = 0;
    int unsigned in_gap        = 0;
    int unsigned out_gap       = 0;
    int unsigned launches      = 0;
    int unsigned out_cycles    = 0;
    logic        in_idle_on    = 1'b1;
    logic        out_idle_on   = 1'b1;

    // Receiver state as the bench tracks it
    logic [31:0]      next_seq  = '0;
    logic [IDX_W-1:0] dg_count  = '0;
    logic [31:0]      seq_w     = '0;
    logic [31:0]      type_w    = '0;
    logic [31:0]      size_w    = '0;
    logic [31:0]      check_w   = '0;
    logic [31:0]      body_sum  = '0;

    // In-order sequence as the stimulus side sees it
    logic [31:0]      gen_seq   = '0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    reliable_transfer_receiver_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .end_of_datagram(end_of_datagram),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .payload_byte(payload_byte),
        .verdict(verdict),
        .ack_valid(ack_valid),
        .ack_seq(ack_seq),
        .ack_checksum(ack_checksum),
        .last_of_run(last_of_run)
    );

    // Advance the tracked receiver by one accepted byte and queue the result
    // words it causes: a payload word inside the declared size and payload limit,
    // then the verdict word when the end mark is set.
    task automatic track_datagram(input logic [7:0] b, input logic eod);
        result_t     r;
        logic [31:0] off;
        logic        bad_shape;
        if (dg_count < HDR_BYTES)
        begin
            case (dg_count[3:2])
                FLD_SEQ:   seq_w[{dg_count[1:0], 3'b000} +: 8] = b;
                FLD_TYPE:  type_w[{dg_count[1:0], 3'b000} +: 8] = b;
                FLD_SIZE:  size_w[{dg_count[1:0], 3'b000} +: 8] = b;
                default:   check_w[{dg_count[1:0], 3'b000} +: 8] = b;
            endcase
        end
        else
        begin
            off = 32'(dg_count) - 32'(HDR_BYTES);
            // drop bytes past the declared size or past the payload limit
            if (off < MAX_PAYLOAD && off < size_w)
            begin
                body_sum = body_sum + 32'(b);
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.last_of_run = !eod;
                results_due.push_back(r);
            end
        end
        if (dg_count != IDX_MAX)
            dg_count = dg_count + 1'b1;

        if (eod)
        begin
            r = '0;
            r.kind = KIND_VERDICT;
            r.last_of_run = 1'b1;
            // shape is judged before checksum and type
            if (size_w > MAX_PAYLOAD)
                bad_shape = 1'b1;
            else
                bad_shape = 32'(dg_count) < 32'(HDR_BYTES) + size_w;
            if (bad_shape)
                r.verdict = VERD_MALFORMED;
            else if (seq_w + type_w + size_w + body_sum != check_w || type_w != '0)
                r.verdict = VERD_BAD;
            else if (seq_w == next_seq)
            begin
                r.verdict = VERD_ACCEPT;
                r.ack_valid = 1'b1;
                r.ack_seq = next_seq;
                next_seq = next_seq + 32'd1;
            end
            else
            begin
                // re-ack the last good sequence, or zero before any
                r.verdict = VERD_REACK;
                r.ack_valid = 1'b1;
                r.ack_seq = (next_seq == '0) ? '0 : next_seq - 32'd1;
            end
            if (r.ack_valid)
                r.ack_checksum = r.ack_seq + 32'd1;
            results_due.push_back(r);
            dg_count = '0;
            seq_w    = '0;
            type_w   = '0;
            size_w   = '0;
            check_w  = '0;
            body_sum = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            if (err_count < MAX_REPORTS)
                $error("%s mismatch: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    task automatic push_word(input logic [7:0] data, input logic eod);
        words_to_send.push_back({data, eod});
        words_queued++;
    endtask

    // Queue one datagram: header, then body_len random bytes. The checksum
    // field is the correct sum xor check_flip. A nonzero keep cuts the
    // datagram to that many bytes.
    task automatic queue_datagram(input logic [31:0] seq, input logic [31:0] typ,
                                  input logic [31:0] size, input int unsigned body_len,
                                  input int unsigned keep, input logic [31:0] check_flip);
        logic [7:0]   body[$];
        logic [127:0] hdr;
        logic [31:0]  sum;
        int unsigned  total;
        sum = seq + typ + size;
        for (int unsigned i = 0; i < body_len; i++)
        begin
            body.push_back(8'($urandom()));
            if (i < size && i < MAX_PAYLOAD)
                sum = sum + 32'(body[i]);
        end
        hdr = {sum ^ check_flip, size, typ, seq};
        total = (keep != 0) ? keep : HDR_BYTES + body_len;
        for (int unsigned i = 0; i < total; i++)
            push_word((i < HDR_BYTES) ? hdr[8*i +: 8] : body[i - HDR_BYTES], i == total - 1);
    endtask

    task automatic queue_noise(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            push_word(8'($urandom()), i == len - 1);
    endtask

    function automatic logic [31:0] pick_size();
        if ($urandom_range(0, 3) == 0)
            return 32'($urandom_range(13, 64));
        return 32'($urandom_range(0, 12));
    endfunction

    // Stimulus, reset, and end of run
    initial
    begin
        logic [31:0] sz;
        logic [31:0] sq;
        logic [31:0] ty;
        int unsigned pick;
        int unsigned dg_no;

        // Directed: header cut after one byte, out-of-order before any accept
        // (acks zero), and an in-order packet whose end mark sits on payload.
        queue_datagram(32'd7, '0, '0, 0, 1, '0);
        queue_datagram(32'd5, '0, '0, 0, 0, '0);
        queue_datagram(gen_seq, '0, 32'd1, 1, 0, '0);
        gen_seq = gen_seq + 32'd1;

        dg_no = 0;
        while (words_queued < SMALL_BYTES)
        begin
            sz = pick_size();
            pick = $urandom_range(0, 99);
            if (dg_no == 3)
            begin
                // full payload, then a tail past the payload limit
                queue_datagram(gen_seq, '0, MAX_PAYLOAD, BIG_LEN - HDR_BYTES, 0, '0);
                gen_seq = gen_seq + 32'd1;
            end
            else if (pick < 40)
            begin
                queue_datagram(gen_seq, '0, sz, sz, 0, '0);
                gen_seq = gen_seq + 32'd1;
            end
            else if (pick < 48)
            begin
                // extra bytes after the declared size
                queue_datagram(gen_seq, '0, sz, sz + $urandom_range(1, 6), 0, '0);
                gen_seq = gen_seq + 32'd1;
            end
            else if (pick < 60)
            begin
                sq = ($urandom_range(0, 1) == 0) ? gen_seq - 32'd1 : 32'($urandom());
                if (sq == gen_seq)
                    sq = gen_seq + 32'd1;
                queue_datagram(sq, '0, sz, sz, 0, '0);
            end
            else if (pick < 68)
                queue_datagram(gen_seq, '0, sz, sz, 0, 32'd1 << $urandom_range(0, 31));
            else if (pick < 75)
            begin
                ty = ($urandom_range(0, 1) == 0) ? 32'd1 : 32'($urandom());
                if (ty == '0)
                    ty = 32'hFFFF_FFFF;
                queue_datagram(gen_seq, ty, sz, sz, 0, '0);
            end
            else if (pick < 84)
                queue_datagram(gen_seq, '0, sz, sz, $urandom_range(1, HDR_BYTES + sz - 1), '0);
            else if (pick < 90)
            begin
                case ($urandom_range(0, 2))
                    0:       ty = MAX_PAYLOAD + 1;
                    1:       ty = 32'hFFFF_FFFF;
                    default: ty = 32'($urandom_range(MAX_PAYLOAD + 2, 32'hFFFF_FFFE));
                endcase
                queue_datagram(gen_seq, '0, ty, $urandom_range(0, 8), 0, '0);
            end
            else
                queue_noise($urandom_range(1, 40));
            dg_no++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Sample away from the active edge: wait for all words in and out
        @(negedge clk);
        while (words_taken != words_queued || results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Input driver: hold a word until it is taken, then advance or idle a burst
    always @(posedge clk)
    begin
        rx_word_t w;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_gap == 0 && in_idle_on && words_to_send.size() > TAIL_WORDS
                && $urandom_range(0, 9) == 0)
                in_gap = $urandom_range(1, 17);
            if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (words_to_send.size() != 0)
            begin
                w = words_to_send.pop_front();
                in_valid <= 1'b1;
                rx_byte <= w.data;
                end_of_datagram <= w.eod;
                launches++;
                // switch between idling and back-to-back stretches
                if (launches % 90 == 0)
                    in_idle_on = ($urandom_range(0, 2) != 0);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: stall in bursts, none in the final stretch
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_cycles++;
            if (out_cycles % 97 == 0)
                out_idle_on = ($urandom_range(0, 2) != 0);
            if (out_gap == 0 && out_idle_on && words_to_send.size() > TAIL_WORDS
                && $urandom_range(0, 9) == 0)
                out_gap = $urandom_range(1, 17);
            if (out_gap != 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted byte, check every accepted result
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                track_datagram(rx_byte, end_of_datagram);
                words_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    if (err_count < MAX_REPORTS)
                        $error("result word with none expected: kind %0d verdict %0d",
                               kind, verdict);
                    err_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("kind", want.kind, kind);
                    compare_field("payload_byte", want.payload_byte, payload_byte);
                    compare_field("verdict", want.verdict, verdict);
                    compare_field("ack_valid", want.ack_valid, ack_valid);
                    compare_field("ack_seq", want.ack_seq, ack_seq);
                    compare_field("ack_checksum", want.ack_checksum, ack_checksum);
                    compare_field("last_of_run", want.last_of_run, last_of_run);
                end
            end
            // watchdog: end the run when nothing moves for too long
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

endmodule
